@@ hw/rtl/ntsf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ntsf_pkg;

    // item operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_FIND  = 1'b1;

    // word 1 value that marks an entry as a timer
    localparam logic [15:0] TIMER_MARK = 16'hffff;

    localparam int LINE_W = 9;
    localparam int LINK_W = 6;
    localparam int WORD_W = 16;

    // word slot inside an entry
    typedef enum logic [1:0] {
        SLOT_W0 = 2'd0,
        SLOT_W1 = 2'd1,
        SLOT_W2 = 2'd2,
        SLOT_W3 = 2'd3
    } slot_t;

    // write request into the object RAM
    typedef struct packed {
        logic              en;
        slot_t             slot;
        logic [WORD_W-1:0] data;
    } ram_wr_t;

    // decoded entry as stored: timer line, timer flag and link
    typedef struct packed {
        logic [LINE_W-1:0] line;
        logic              timer;
        logic [LINK_W-1:0] link;
    } obj_entry_t;

    // line = 255 - (w0 >> 5) - ((w0 & 15) + 1) * 8, mod 512
    function automatic logic [LINE_W-1:0] timer_line(input logic [WORD_W-1:0] w0);
        logic [LINE_W-1:0] vsize8;
        vsize8 = {1'b0, 5'(w0[3:0]) + 5'd1, 3'b000};
        return 9'd255 - w0[13:5] - vsize8;
    endfunction

    // line of a cleared entry (word 0 all zeros)
    localparam logic [LINE_W-1:0] ZERO_W0_LINE = timer_line(16'h0000);

endpackage

`default_nettype wire

@@ hw/rtl/ntsf_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface ntsf_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [10:0] word_address;
    logic [15:0] write_value;
    logic [8:0] scanline;

    modport source (output valid, output op, output word_address, output write_value,
                    output scanline, input ready);
    modport sink (input valid, input op, input word_address, input write_value,
                  input scanline, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/ntsf_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface ntsf_out_if;
    logic       valid;
    logic       ready;
    logic       found;
    logic [8:0] next_line;
    logic       changed;

    modport source (output valid, output found, output next_line, output changed,
                    input ready);
    modport sink (input valid, input found, input next_line, input changed,
                  output ready);
endinterface

`default_nettype wire

@@ hw/rtl/ntsf_obj_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ntsf_obj_ram #(
    parameter int AW = 9
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  ntsf_pkg::ram_wr_t    wr,
    input  wire [AW-1:0]         wr_addr,
    input  wire                  rd_en,
    input  wire [AW-1:0]         rd_addr,
    output ntsf_pkg::obj_entry_t rd_entry,
    output logic                 clearing
);

    localparam int DEPTH = 2 ** AW;

    // word 2 is never read by a find, so it is not stored
    logic [ntsf_pkg::LINE_W-1:0] line_mem  [DEPTH];
    logic                        timer_mem [DEPTH];
    logic [ntsf_pkg::LINK_W-1:0] link_mem  [DEPTH];

    logic          clearing_reg;
    logic [AW-1:0] clr_addr_reg;
    ntsf_pkg::obj_entry_t rd_entry_reg;

    // clearing sweep after reset, one row per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == AW'(DEPTH - 1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // write port: sweep or one decoded word
    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            line_mem[clr_addr_reg]  <= ntsf_pkg::ZERO_W0_LINE;
            timer_mem[clr_addr_reg] <= 1'b0;
            link_mem[clr_addr_reg]  <= '0;
        end
        else if (wr.en)
        begin
            case (wr.slot)
                ntsf_pkg::SLOT_W0: line_mem[wr_addr]  <= ntsf_pkg::timer_line(wr.data);
                ntsf_pkg::SLOT_W1: timer_mem[wr_addr] <= (wr.data == ntsf_pkg::TIMER_MARK);
                ntsf_pkg::SLOT_W3: link_mem[wr_addr]  <= wr.data[ntsf_pkg::LINK_W-1:0];
                default: ;
            endcase
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_entry_reg.line  <= line_mem[rd_addr];
            rd_entry_reg.timer <= timer_mem[rd_addr];
            rd_entry_reg.link  <= link_mem[rd_addr];
        end
    end

    assign rd_entry = rd_entry_reg;
    assign clearing = clearing_reg;

endmodule

`default_nettype wire

@@ hw/rtl/next_timer_scanline_finder.sv @@
// Next timer scanline finder.
// Input channel (in_ch) takes items of two kinds. A write (op 0) stores one
// 16-bit word of the object RAM at word_address = bank(3) slot(2) entry(6);
// it gives no result. A find (op 1) walks the link chain of the bank in the
// bank select register from entry 0 and gives one result item on out_ch:
// found, next_line and changed against the last result. The walk makes one
// object RAM read per entry on the chain (at most ENTRIES_PER_BANK entries),
// each read feeding the next link.
// in_ch.ready is low while a find runs, so finds are handled one at a time.
// The result sits in an output register; if out_ch stalls, the next write
// items are still taken, and a later find waits before reporting until the
// register is free.
// After reset the object RAM is swept to all-zero words, one row per cycle, over
// all 2**(bank bits + entry bits) rows with in_ch.ready low. The user must write
// the bank select register via cfg_wr_en only while idle; it is not enforced.
`timescale 1ns / 1ps
`default_nettype none

module next_timer_scanline_finder #(
    parameter int ENTRIES_PER_BANK = 64,
    parameter int BANK_COUNT       = 8
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_wr_en,
    input  wire  [2:0]  cfg_wr_data,
    ntsf_in_if.sink     in_ch,
    ntsf_out_if.source  out_ch
);

    localparam int EW = $clog2(ENTRIES_PER_BANK);
    localparam int BW = (BANK_COUNT > 1) ? $clog2(BANK_COUNT) : 1;
    localparam int AW = BW + EW;
    localparam int LW = ntsf_pkg::LINE_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINISH
    } state_t;

    state_t                 state_reg;
    logic [2:0]             search_bank_reg;
    logic [ENTRIES_PER_BANK-1:0] visited_reg;
    logic [LW-1:0]          scan_reg;
    logic [LW-1:0]          best_reg;
    logic                   found_reg;
    logic                   last_valid_reg;
    logic [LW-1:0]          last_line_reg;
    logic                   out_valid_reg;
    logic                   out_found_reg;
    logic [LW-1:0]          out_line_reg;
    logic                   out_changed_reg;

    logic                   clearing;
    logic                   in_accept;
    logic                   find_start;
    ntsf_pkg::ram_wr_t      ram_wr;
    logic [AW-1:0]          wr_addr;
    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    ntsf_pkg::obj_entry_t   entry;
    logic [EW-1:0]          next_link;
    logic [BW-1:0]          bank_sel;
    logic                   take_line;
    logic [LW-1:0]          best_next;
    logic                   changed_now;
    logic                   out_free;

    // modulo tables for the bank register and the 6-bit link
    logic [BW-1:0] bank_lut [8];
    logic [EW-1:0] link_lut [64];

    for (genvar g = 0; g < 8; g++)
    begin : g_bank_lut
        assign bank_lut[g] = BW'(g % BANK_COUNT);
    end

    for (genvar g = 0; g < 64; g++)
    begin : g_link_lut
        assign link_lut[g] = EW'(g % ENTRIES_PER_BANK);
    end

    assign bank_sel = bank_lut[search_bank_reg];

    // input handshake
    assign in_ch.ready = (state_reg == ST_IDLE) && !clearing;
    assign in_accept   = in_ch.valid && in_ch.ready;
    assign find_start  = in_accept && (in_ch.op == ntsf_pkg::OP_FIND);

    // write decode: out-of-range bank or entry is dropped
    always_comb
    begin
        ram_wr.en   = in_accept && (in_ch.op == ntsf_pkg::OP_WRITE)
                      && (32'(in_ch.word_address[10:8]) < BANK_COUNT)
                      && (32'(in_ch.word_address[5:0]) < ENTRIES_PER_BANK);
        ram_wr.slot = ntsf_pkg::slot_t'(in_ch.word_address[7:6]);
        ram_wr.data = in_ch.write_value;
        wr_addr     = {BW'(in_ch.word_address[10:8]), EW'(in_ch.word_address[5:0])};
    end

    // chain walk: the read data of one entry gives the next read address
    assign next_link = link_lut[entry.link];
    assign rd_en     = find_start || ((state_reg == ST_WALK) && !visited_reg[next_link]);
    assign rd_addr   = {bank_sel, (state_reg == ST_IDLE) ? EW'(0) : next_link};

    ntsf_obj_ram #(
        .AW (AW)
    ) u_obj_ram (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (ram_wr),
        .wr_addr  (wr_addr),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_entry (entry),
        .clearing (clearing)
    );

    // selection: a timer line below the best, or above the scanline while the best is at or below it, is taken
    always_comb
    begin
        if (best_reg <= scan_reg)
        begin
            take_line = ((entry.line <= scan_reg) && (entry.line < best_reg))
                        || (entry.line > scan_reg);
        end
        else
        begin
            take_line = (entry.line < best_reg);
        end
        best_next = (entry.timer && take_line) ? entry.line : best_reg;
    end

    // compare against the last reported result
    assign changed_now = found_reg ? (!last_valid_reg || (last_line_reg != best_reg))
                                   : last_valid_reg;
    assign out_free    = !out_valid_reg || out_ch.ready;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            search_bank_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            search_bank_reg <= cfg_wr_data;
        end
    end

    // sequencer, walk registers and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            visited_reg     <= '0;
            found_reg       <= 1'b0;
            last_valid_reg  <= 1'b0;
            last_line_reg   <= '0;
            out_valid_reg   <= 1'b0;
            out_found_reg   <= 1'b0;
            out_line_reg    <= '0;
            out_changed_reg <= 1'b0;
            scan_reg        <= '0;
            best_reg        <= '0;
        end
        else
        begin
            // result register: loaded when a find finishes, freed on acceptance
            if ((state_reg == ST_FINISH) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (find_start)
                    begin
                        visited_reg    <= ENTRIES_PER_BANK'(1);
                        scan_reg       <= in_ch.scanline;
                        best_reg       <= in_ch.scanline;
                        found_reg      <= 1'b0;
                        state_reg      <= ST_WALK;
                    end
                end
                ST_WALK:
                begin
                    best_reg  <= best_next;
                    found_reg <= found_reg || entry.timer;
                    if (visited_reg[next_link])
                    begin
                        state_reg <= ST_FINISH;
                    end
                    else
                    begin
                        visited_reg[next_link] <= 1'b1;
                    end
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        out_found_reg   <= found_reg;
                        out_line_reg    <= found_reg ? best_reg : '0;
                        out_changed_reg <= changed_now;
                        last_valid_reg  <= found_reg;
                        last_line_reg   <= found_reg ? best_reg : '0;
                        state_reg       <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.found     = out_found_reg;
    assign out_ch.next_line = out_line_reg;
    assign out_ch.changed   = out_changed_reg;

`ifndef SYNTH
    // entry 0 is always on the chain while walking
    a_walk_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> visited_reg[0])
        else $error("walk without entry 0 marked");

    // an accepted find starts a walk
    a_find_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready && (in_ch.op == ntsf_pkg::OP_FIND))
        |=> (state_reg == ST_WALK))
        else $error("find not started");

    // no result line without a timer
    a_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_found_reg || (out_line_reg == '0)))
        else $error("line reported without timer");

    // no items taken during the RAM sweep
    a_sweep_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !in_ch.ready)
        else $error("item taken during RAM sweep");
`endif

endmodule

`default_nettype wire
